/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Types, codes and sizes that the queue cells and the top level share.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Number of cells in the chain, and the width of a count of them.
	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int ID_W     = 16;
	localparam int PRIO_W   = 4;
	localparam int OCC_W    = 5;
	localparam int STATUS_W = 2;

	// Operation codes carried in the func field.
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DELETE = 1'b1;

	// Status codes reported with every result item.
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic              func;
		logic [ID_W-1:0]   entry_id;
		logic [PRIO_W-1:0] entry_priority;
	} in_item_t;

	typedef struct packed {
		logic                head_valid;
		logic [ID_W-1:0]     head_id;
		logic [PRIO_W-1:0]   head_priority;
		logic [OCC_W-1:0]    entry_count;
		logic [STATUS_W-1:0] status;
	} out_item_t;

	// Contents of one cell.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} slot_t;

	// Operation broadcast to every cell.
	typedef struct packed {
		logic  wr;   // the chain updates in this cycle
		logic  ins;  // insert when set, delete otherwise
		slot_t data; // new entry, or the id to delete
	} op_t;

	// Flags handed from one cell to the next, towards the tail.
	typedef struct packed {
		logic after; // the new entry goes after this cell and all before it
		logic found; // the id to delete was matched at or before this cell
	} link_t;

endpackage

/* rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain. On insert it keeps its entry, takes the new
// one or takes its left neighbour's; on delete it keeps its entry or takes
// its right neighbour's.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic          clk,
	input  spq_pkg::op_t  op,
	input  logic          occupied,
	input  spq_pkg::link_t link_in,
	input  spq_pkg::slot_t left_slot,
	input  spq_pkg::slot_t right_slot,
	output spq_pkg::link_t link_out,
	output spq_pkg::slot_t slot,
	output spq_pkg::slot_t slot_next
);
	import spq_pkg::*;

	slot_t slot_q;
	logic  match;

	// The new entry belongs after this cell if it holds a priority no larger.
	// The first cell that holds the id starts the found flag down the chain.
	always_comb begin
		match          = occupied && (slot_q.id == op.data.id);
		link_out.after = occupied && (slot_q.prio <= op.data.prio);
		link_out.found = link_in.found || match;
	end

	// Next contents: shift towards the tail on insert, towards the head on delete.
	always_comb begin
		slot_next = slot_q;
		if (op.ins) begin
			if (!link_out.after) begin
				slot_next = link_in.after ? op.data : left_slot;
			end
		end else if (link_out.found) begin
			slot_next = right_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (op.wr) begin
			slot_q <= slot_next;
		end
	end

	assign slot = slot_q;

endmodule

/* rtl/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue kept in a chain of cells sorted by ascending priority; equal
// priorities leave in arrival order. Insert or delete-by-id on each item,
// with one result item giving the head, the count and a status.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------
//  in      | input     | in_valid / in_ready   | in_item  (in_item_t)
//  out     | output    | out_valid / out_ready | out_item (out_item_t)
//
// Every cell decides its next contents in parallel, and the chain and the result
// are registered at the same edge, so an item can be taken in every cycle while
// the output register is free or being emptied.
// The found flag of a delete ripples through all cells combinationally.
// Reset empties the queue; cell contents are not cleared and are never read
// beyond the count. A stalled result holds off further items.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spq_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output spq_pkg::out_item_t  out_item
);
	import spq_pkg::*;

	logic                 accept;
	logic                 full;
	logic                 found;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_next;
	logic [STATUS_W-1:0]  status;
	logic [CNT_W+OCC_W-1:0] count_ext;
	op_t                  op;
	link_t                links [QUEUE_DEPTH+1];
	slot_t                slots [QUEUE_DEPTH];
	slot_t                slots_next [QUEUE_DEPTH];
	slot_t                head_next;
	logic                 out_valid_q;
	out_item_t            out_item_q;

	// Take an item when the result register is free or being emptied.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign found    = links[QUEUE_DEPTH].found;

	// Broadcast operation; a full insert and an unmatched delete write nothing.
	always_comb begin
		op.ins     = (in_item.func == FUNC_INSERT);
		op.data.id = in_item.entry_id;
		op.data.prio = in_item.entry_priority;
		op.wr      = accept && (op.ins ? !full : found);
	end

	// The head of the chain sees a new entry as going after nothing.
	assign links[0].after = 1'b1;
	assign links[0].found = 1'b0;

	// Chain of cells, head at index zero.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		slot_t left_slot;
		slot_t right_slot;

		if (i == 0) begin : g_head
			assign left_slot = '0;
		end else begin : g_body
			assign left_slot = slots[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_slot = slots[i];
		end else begin : g_inner
			assign right_slot = slots[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.op         (op),
			.occupied   (count_q > CNT_W'(i)),
			.link_in    (links[i]),
			.left_slot  (left_slot),
			.right_slot (right_slot),
			.link_out   (links[i+1]),
			.slot       (slots[i]),
			.slot_next  (slots_next[i])
		);
	end

	// Count and status after the operation.
	always_comb begin
		count_next = count_q;
		status     = ST_DONE;
		if (op.ins) begin
			if (full) begin
				status = ST_FULL;
			end else begin
				count_next = count_q + CNT_W'(1);
			end
		end else begin
			if (found) begin
				count_next = count_q - CNT_W'(1);
			end else begin
				status = ST_NOT_FOUND;
			end
		end
	end

	assign count_ext = {{OCC_W{1'b0}}, count_next};

	// The head cell only changes when the chain is written.
	assign head_next = op.wr ? slots_next[0] : slots[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register; the head comes from the head cell's next contents.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q.head_valid    <= (count_next != '0);
			out_item_q.head_id       <= (count_next != '0) ? head_next.id : '0;
			out_item_q.head_priority <= (count_next != '0) ? head_next.prio : '0;
			out_item_q.entry_count   <= count_ext[OCC_W-1:0];
			out_item_q.status        <= status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// The count never passes the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	// A dropped insert leaves the count as it was.
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op.ins && full) |=> (count_q == $past(count_q)))
		else $error("insert into full queue changed the count");

	// A delete on an empty queue reports not found.
	a_empty_delete: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !op.ins && (count_q == '0)) |=>
		(out_item_q.status == ST_NOT_FOUND))
		else $error("delete on empty queue not flagged");

	// The two cells nearest the head stay in priority order.
	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (slots[0].prio <= slots[1].prio))
		else $error("head cells out of order");

endmodule
